// ----- design/dpat_pkg.sv -----
// ----------------------------------------------------------------------------
// dpat_pkg
// Shared types and constants for the distance presence detector with an
// adaptive threshold.
// ----------------------------------------------------------------------------
`default_nettype none

package dpat_pkg;

	// Field widths of the channels and of the configuration port.
	localparam int TIME_W      = 32;
	localparam int DIST_W      = 9;
	localparam int THR_W       = 10;
	localparam int SENSE_W     = 16;
	localparam int SENS_W      = 9;
	localparam int DELAY_W     = 20;
	localparam int PERIOD_W    = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;

	// Default number of baseline entries that are averaged.
	localparam int RING_SIZE   = 6;

	// Offset subtracted from the baseline mean.
	localparam int THR_OFFSET  = 10;

	// Reset values of the configuration registers.
	localparam logic                EN_RST      = 1'b1;
	localparam logic [SENSE_W-1:0]  SENSE_RST   = 16'd100;
	localparam logic [SENS_W-1:0]   SENS_RST    = 9'd2;
	localparam logic [DELAY_W-1:0]  DELAY_RST   = 20'd5000;
	localparam logic [DIST_W-1:0]   DEF_THR_RST = 9'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 20'd60000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE          = 3'd0,
		REG_SENSE_INTERVAL  = 3'd1,
		REG_CHANGE_SENS     = 3'd2,
		REG_CLEAR_DELAY     = 3'd3,
		REG_DEFAULT_THR     = 3'd4,
		REG_BASELINE_PERIOD = 3'd5
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_DRAIN,
		S_DIV1,
		S_DIV2,
		S_DONE
	} state_t;

	// Commands to the baseline ring memory.
	typedef struct packed {
		logic wr;
		logic rd;
	} ring_cmd_t;

	// Commands to the averaging unit.
	typedef struct packed {
		logic clr;
		logic mul;
	} avg_ctl_t;

endpackage

`default_nettype wire

// ----- design/dpat_if.sv -----
// ----------------------------------------------------------------------------
// dpat_if
// Valid/ready channels for the distance samples and for the detector results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpat_in_if;
	logic                       valid;
	logic                       ready;
	logic [dpat_pkg::TIME_W-1:0] now_ms;
	logic [dpat_pkg::DIST_W-1:0] distance_cm;

	modport source (output valid, output now_ms, output distance_cm, input ready);
	modport sink   (input valid, input now_ms, input distance_cm, output ready);
endinterface

interface dpat_out_if;
	logic                              valid;
	logic                              ready;
	logic                              sampled;
	logic                              changed;
	logic                              present;
	logic [dpat_pkg::DIST_W-1:0]        held_distance;
	logic signed [dpat_pkg::THR_W-1:0]  threshold;

	modport source (output valid, output sampled, output changed, output present,
		output held_distance, output threshold, input ready);
	modport sink   (input valid, input sampled, input changed, input present,
		input held_distance, input threshold, output ready);
endinterface

`default_nettype wire

// ----- design/dpat_ring.sv -----
// ----------------------------------------------------------------------------
// dpat_ring
// Baseline ring memory: one write port, one registered read port, and a valid
// bit per entry so that unwritten entries read as the default threshold after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dpat_ring #(
	parameter int RING_SIZE = dpat_pkg::RING_SIZE
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire dpat_pkg::ring_cmd_t      cmd,
	input  wire [$clog2(RING_SIZE)-1:0]   wr_addr,
	input  wire [dpat_pkg::DIST_W-1:0]    wr_data,
	input  wire [$clog2(RING_SIZE)-1:0]   rd_addr,
	input  wire [dpat_pkg::DIST_W-1:0]    def_thr,
	output logic                          term_vld,
	output logic [dpat_pkg::DIST_W-1:0]   term
);

	logic [dpat_pkg::DIST_W-1:0] mem [RING_SIZE];
	logic [RING_SIZE-1:0]        valid_q;
	logic [dpat_pkg::DIST_W-1:0] rd_data_s1;
	logic                        rd_ok_s1;
	logic                        rd_vld_s1;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Entry valid bits and read pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_ok_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= cmd.rd;
			if (cmd.rd) begin
				rd_ok_s1 <= valid_q[rd_addr];
			end
		end
	end

	// Empty or zero entries count as the default threshold.
	always_comb begin
		term_vld = rd_vld_s1;
		term     = (rd_ok_s1 && rd_data_s1 != '0) ? rd_data_s1 : def_thr;
	end

endmodule

`default_nettype wire

// ----- design/dpat_avg.sv -----
// ----------------------------------------------------------------------------
// dpat_avg
// Accumulates the ring entries and forms the threshold as the mean minus the
// offset, dividing by the ring size through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module dpat_avg #(
	parameter int RING_SIZE = dpat_pkg::RING_SIZE
) (
	input  wire                                 clk,
	input  wire dpat_pkg::avg_ctl_t             ctl,
	input  wire                                 term_vld,
	input  wire [dpat_pkg::DIST_W-1:0]          term,
	output logic signed [dpat_pkg::THR_W-1:0]   thr
);

	localparam int SUM_W = $clog2(RING_SIZE * ((1 << dpat_pkg::DIST_W) - 1) + 1);
	localparam int RECIP = (1 << SUM_W) / RING_SIZE;
	localparam int PROD_W = 2 * SUM_W;

	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]  quo;
	logic [PROD_W-1:0] back;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  quo_fix;

	// Running sum and the reciprocal product.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			sum_q <= '0;
		end else if (term_vld) begin
			sum_q <= sum_q + SUM_W'(term);
		end
		if (ctl.mul) begin
			prod_s1 <= sum_q * SUM_W'(RECIP);
		end
	end

	// The estimate is the exact quotient or one below; one compare fixes it.
	always_comb begin
		quo     = prod_s1[PROD_W-1:SUM_W];
		back    = quo * SUM_W'(RING_SIZE);
		rem     = sum_q - back[SUM_W-1:0];
		quo_fix = (rem >= SUM_W'(RING_SIZE)) ? quo + 1'b1 : quo;
		thr     = $signed({1'b0, quo_fix[dpat_pkg::DIST_W-1:0]})
			- dpat_pkg::THR_W'(dpat_pkg::THR_OFFSET);
	end

endmodule

`default_nettype wire

// ----- design/distance_presence_adaptive_threshold.sv -----
// ----------------------------------------------------------------------------
// distance_presence_adaptive_threshold
// Presence detector for a distance sensor with a threshold that follows a
// slowly sampled baseline kept in a small ring memory.
// ----------------------------------------------------------------------------
// Each input transfer gives exactly one result transfer. An item passes from
// its acceptance through the evaluation state straight to the result state,
// in which its result is loaded, when no baseline sample is due, and through
// the read, drain, DIV1 and DIV2 states first when one is: the ring memory
// has one read port, so the new mean is formed by reading one entry a cycle,
// then the last read data is drained and the reciprocal division runs. A
// result that has not been taken holds the item in the result state until the
// output register is free. The next item is accepted as soon as the previous
// one has reached the output register, even if that result has not been taken
// yet. Configuration writes must only be made while no item is in flight.
`default_nettype none

module distance_presence_adaptive_threshold #(
	parameter int RING_SIZE = dpat_pkg::RING_SIZE
) (
	input  wire                               clk,
	input  wire                               arst_n,
	dpat_in_if.sink                           in_ch,
	dpat_out_if.source                        out_ch,
	input  wire                               cfg_we,
	input  wire [dpat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [dpat_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int POS_W = $clog2(RING_SIZE);

	// Configuration registers.
	logic                             en_q;
	logic [dpat_pkg::SENSE_W-1:0]     sense_q;
	logic [dpat_pkg::SENS_W-1:0]      sens_q;
	logic [dpat_pkg::DELAY_W-1:0]     delay_q;
	logic [dpat_pkg::DIST_W-1:0]      def_thr_q;
	logic [dpat_pkg::PERIOD_W-1:0]    period_q;

	// Detector state.
	logic [dpat_pkg::TIME_W-1:0]      last_sample_q;
	logic [dpat_pkg::TIME_W-1:0]      last_trigger_q;
	logic [dpat_pkg::TIME_W-1:0]      last_base_q;
	logic [dpat_pkg::DIST_W-1:0]      held_q;
	logic                             present_q;
	logic                             changed_q;
	logic signed [dpat_pkg::THR_W-1:0] thr_q;
	logic [POS_W-1:0]                 pos_q;
	logic                             sampled_q;

	// Item being worked on.
	logic [dpat_pkg::TIME_W-1:0]      now_q;
	logic [dpat_pkg::DIST_W-1:0]      dist_q;
	logic [POS_W-1:0]                 rd_idx_q;

	// Output register.
	logic                             out_vld_q;
	logic                             out_sampled_q;
	logic                             out_changed_q;
	logic                             out_present_q;
	logic [dpat_pkg::DIST_W-1:0]      out_held_q;
	logic signed [dpat_pkg::THR_W-1:0] out_thr_q;

	dpat_pkg::state_t    state_q, state_d;
	dpat_pkg::ring_cmd_t ring_cmd;
	dpat_pkg::avg_ctl_t  avg_ctl;

	logic                             term_vld;
	logic [dpat_pkg::DIST_W-1:0]      term;
	logic signed [dpat_pkg::THR_W-1:0] avg_thr;

	// Evaluation of one item.
	logic [dpat_pkg::TIME_W-1:0]      since_sample;
	logic [dpat_pkg::TIME_W-1:0]      since_trigger;
	logic [dpat_pkg::TIME_W-1:0]      since_base;
	logic                             take;
	logic                             clear_ok;
	logic [dpat_pkg::DIST_W-1:0]      abs_diff;
	logic                             update;
	logic                             trigger;
	logic                             base_due;
	logic                             out_load;

	always_comb begin
		since_sample  = now_q - last_sample_q;
		since_trigger = now_q - last_trigger_q;
		since_base    = now_q - last_base_q;
		take          = en_q && (since_sample >= dpat_pkg::TIME_W'(sense_q));
		clear_ok      = ($signed({2'b00, held_q}) > $signed({thr_q[dpat_pkg::THR_W-1], thr_q})
			|| held_q == '0) && (since_trigger >= dpat_pkg::TIME_W'(delay_q));
		abs_diff      = (dist_q >= held_q) ? dist_q - held_q : held_q - dist_q;
		update        = abs_diff > sens_q;
		trigger       = update && dist_q != '0
			&& $signed({2'b00, dist_q}) < $signed({thr_q[dpat_pkg::THR_W-1], thr_q});
		base_due      = since_base >= dpat_pkg::TIME_W'(period_q);
		out_load      = state_q == dpat_pkg::S_DONE && (!out_vld_q || out_ch.ready);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= dpat_pkg::EN_RST;
			sense_q   <= dpat_pkg::SENSE_RST;
			sens_q    <= dpat_pkg::SENS_RST;
			delay_q   <= dpat_pkg::DELAY_RST;
			def_thr_q <= dpat_pkg::DEF_THR_RST;
			period_q  <= dpat_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			unique case (dpat_pkg::reg_idx_t'(cfg_index))
				dpat_pkg::REG_ENABLE:          en_q      <= cfg_data[0];
				dpat_pkg::REG_SENSE_INTERVAL:  sense_q   <= cfg_data[dpat_pkg::SENSE_W-1:0];
				dpat_pkg::REG_CHANGE_SENS:     sens_q    <= cfg_data[dpat_pkg::SENS_W-1:0];
				dpat_pkg::REG_CLEAR_DELAY:     delay_q   <= cfg_data[dpat_pkg::DELAY_W-1:0];
				dpat_pkg::REG_DEFAULT_THR:     def_thr_q <= cfg_data[dpat_pkg::DIST_W-1:0];
				dpat_pkg::REG_BASELINE_PERIOD: period_q  <= cfg_data[dpat_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands to the ring and the averaging unit.
	always_comb begin
		state_d     = state_q;
		ring_cmd    = '0;
		avg_ctl     = '0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			dpat_pkg::S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = dpat_pkg::S_EVAL;
				end
			end
			dpat_pkg::S_EVAL: begin
				avg_ctl.clr = 1'b1;
				if (take && base_due) begin
					ring_cmd.wr = 1'b1;
					state_d     = dpat_pkg::S_READ;
				end else begin
					state_d = dpat_pkg::S_DONE;
				end
			end
			dpat_pkg::S_READ: begin
				ring_cmd.rd = 1'b1;
				if (rd_idx_q == POS_W'(RING_SIZE - 1)) begin
					state_d = dpat_pkg::S_DRAIN;
				end
			end
			dpat_pkg::S_DRAIN: begin
				state_d = dpat_pkg::S_DIV1;
			end
			dpat_pkg::S_DIV1: begin
				avg_ctl.mul = 1'b1;
				state_d     = dpat_pkg::S_DIV2;
			end
			dpat_pkg::S_DIV2: begin
				state_d = dpat_pkg::S_DONE;
			end
			dpat_pkg::S_DONE: begin
				if (out_load) begin
					state_d = dpat_pkg::S_IDLE;
				end
			end
			default: state_d = dpat_pkg::S_IDLE;
		endcase
	end

	// Item capture and the ring read counter.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			now_q  <= in_ch.now_ms;
			dist_q <= in_ch.distance_cm;
		end
		if (state_q == dpat_pkg::S_EVAL) begin
			rd_idx_q <= '0;
		end else if (ring_cmd.rd) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// Detector state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q  <= '0;
			last_trigger_q <= '0;
			last_base_q    <= '0;
			held_q         <= '0;
			present_q      <= 1'b0;
			changed_q      <= 1'b0;
			thr_q          <= dpat_pkg::THR_W'(signed'({1'b0, dpat_pkg::DEF_THR_RST}));
			pos_q          <= '0;
			sampled_q      <= 1'b0;
		end else begin
			if (state_q == dpat_pkg::S_EVAL) begin
				sampled_q <= take;
				if (take) begin
					last_sample_q <= now_q;
					changed_q     <= update;
					if (update) begin
						held_q <= dist_q;
					end
					if (trigger) begin
						present_q      <= 1'b1;
						last_trigger_q <= now_q;
					end else if (clear_ok) begin
						present_q <= 1'b0;
					end
					if (base_due) begin
						last_base_q <= now_q;
						pos_q <= (pos_q == POS_W'(RING_SIZE - 1)) ? '0 : pos_q + 1'b1;
					end
				end
			end
			if (state_q == dpat_pkg::S_DIV2) begin
				thr_q <= avg_thr;
			end
		end
	end

	// Output register: loads while the previous result is taken or gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sampled_q <= sampled_q;
			out_changed_q <= changed_q;
			out_present_q <= present_q;
			out_held_q    <= held_q;
			out_thr_q     <= thr_q;
		end
	end

	always_comb begin
		out_ch.valid         = out_vld_q;
		out_ch.sampled       = out_sampled_q;
		out_ch.changed       = out_changed_q;
		out_ch.present       = out_present_q;
		out_ch.held_distance = out_held_q;
		out_ch.threshold     = out_thr_q;
	end

	dpat_ring #(
		.RING_SIZE (RING_SIZE)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ring_cmd),
		.wr_addr  (pos_q),
		.wr_data  (dist_q),
		.rd_addr  (rd_idx_q),
		.def_thr  (def_thr_q),
		.term_vld (term_vld),
		.term     (term)
	);

	dpat_avg #(
		.RING_SIZE (RING_SIZE)
	) u_avg (
		.clk      (clk),
		.ctl      (avg_ctl),
		.term_vld (term_vld),
		.term     (term),
		.thr      (avg_thr)
	);

	// The ring write pointer always names an existing entry.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < RING_SIZE)
		else $error("ring position out of range");

	// The threshold stays within the mean-minus-offset range.
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		thr_q >= -dpat_pkg::THR_W'(dpat_pkg::THR_OFFSET) && thr_q <= 10'sd501)
		else $error("threshold out of range");

	// Read data is only returned in the cycle after a sweep read.
	a_term_timing: assert property (@(posedge clk) disable iff (!arst_n)
		term_vld |-> state_q == dpat_pkg::S_READ || state_q == dpat_pkg::S_DRAIN)
		else $error("ring read data outside the averaging sweep");

	// The division always completes into the result state.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dpat_pkg::S_DIV2 |=> state_q == dpat_pkg::S_DONE)
		else $error("division did not finish");

endmodule

`default_nettype wire

// ----- verif/dpat_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpat_checker
// Watches the sample channel, the result channel and the register port of the
// presence detector. It keeps its own copy of the detector state, predicts the
// result of every accepted sample and compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------

module dpat_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	dpat_in_if                             in_ch,
	dpat_out_if                            out_ch,
	input  wire                            cfg_we,
	input  wire [dpat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [dpat_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import dpat_pkg::*;

	typedef struct packed {
		logic              sampled;
		logic              changed;
		logic              present;
		logic [DIST_W-1:0] held;
		logic [THR_W-1:0]  thr;
	} detect_result_t;

	// Register copies.
	logic                sensor_on;
	logic [SENSE_W-1:0]  sense_ivl;
	logic [SENS_W-1:0]   sensitivity;
	logic [DELAY_W-1:0]  clear_delay;
	logic [DIST_W-1:0]   default_thr;
	logic [PERIOD_W-1:0] base_period;

	// Detector state.
	logic [TIME_W-1:0]   t_sample;
	logic [TIME_W-1:0]   t_trigger;
	logic [TIME_W-1:0]   t_baseline;
	logic [DIST_W-1:0]   held_cm;
	logic                present_q;
	logic                changed_q;
	int                  thr_cm;
	logic [DIST_W-1:0]   baseline[RING_SIZE];
	int                  ring_pos;

	detect_result_t      expected_results[$];

	// An interval has passed when the wrapped difference reaches it.
	function automatic logic interval_passed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] then,
		logic [TIME_W-1:0] ivl);
		logic [TIME_W-1:0] gap;
		gap = now - then;
		return gap >= ivl;
	endfunction

	// Advances the detector by one sample and returns the result it shows.
	function automatic detect_result_t detect_step(logic [TIME_W-1:0] now,
		logic [DIST_W-1:0] dist_cm);
		detect_result_t r;
		int             diff;
		int             sum;
		r.sampled = 1'b0;
		if (sensor_on && interval_passed(now, t_sample, TIME_W'(sense_ivl))) begin
			r.sampled = 1'b1;
			t_sample = now;
			// Presence times out only while nobody is seen near.
			if (int'(held_cm) > thr_cm || held_cm == '0) begin
				if (interval_passed(now, t_trigger, TIME_W'(clear_delay)))
					present_q = 1'b0;
			end
			diff = int'(dist_cm) - int'(held_cm);
			if (diff < 0)
				diff = -diff;
			if (diff > int'(sensitivity)) begin
				changed_q = 1'b1;
				held_cm = dist_cm;
				if (int'(dist_cm) < thr_cm && dist_cm != '0) begin
					present_q = 1'b1;
					t_trigger = now;
				end
			end else begin
				changed_q = 1'b0;
			end
			// Baseline update: empty entries stand for the default threshold.
			if (interval_passed(now, t_baseline, TIME_W'(base_period))) begin
				t_baseline = now;
				baseline[ring_pos] = dist_cm;
				ring_pos = (ring_pos + 1) % RING_SIZE;
				sum = 0;
				for (int i = 0; i < RING_SIZE; i++)
					sum += (baseline[i] != '0) ? int'(baseline[i]) : int'(default_thr);
				thr_cm = sum / RING_SIZE - THR_OFFSET;
			end
		end
		r.changed = changed_q;
		r.present = present_q;
		r.held = held_cm;
		r.thr = thr_cm[THR_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Prediction and comparison, evaluated on the values before each edge.
	always @(posedge clk or negedge arst_n) begin
		detect_result_t want;
		if (!arst_n) begin
			sensor_on = EN_RST;
			sense_ivl = SENSE_RST;
			sensitivity = SENS_RST;
			clear_delay = DELAY_RST;
			default_thr = DEF_THR_RST;
			base_period = PERIOD_RST;
			t_sample = '0;
			t_trigger = '0;
			t_baseline = '0;
			held_cm = '0;
			present_q = 1'b0;
			changed_q = 1'b0;
			thr_cm = int'(DEF_THR_RST);
			for (int i = 0; i < RING_SIZE; i++)
				baseline[i] = '0;
			ring_pos = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			// Register writes; indexes past the list are dropped.
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ENABLE:          sensor_on = cfg_data[0];
					REG_SENSE_INTERVAL:  sense_ivl = cfg_data[SENSE_W-1:0];
					REG_CHANGE_SENS:     sensitivity = cfg_data[SENS_W-1:0];
					REG_CLEAR_DELAY:     clear_delay = cfg_data[DELAY_W-1:0];
					REG_DEFAULT_THR:     default_thr = cfg_data[DIST_W-1:0];
					REG_BASELINE_PERIOD: base_period = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end

			// Result transfer against the oldest prediction.
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result transfer expected none, got held %0d thr %0d",
						$time, out_ch.held_distance, out_ch.threshold);
				end else begin
					want = expected_results.pop_front();
					check_field("sampled", want.sampled, out_ch.sampled);
					check_field("changed", want.changed, out_ch.changed);
					check_field("present", want.present, out_ch.present);
					check_field("held_distance", want.held, out_ch.held_distance);
					check_field("threshold", want.thr, $unsigned(out_ch.threshold));
				end
			end

			// Sample transfer.
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				expected_results.push_back(detect_step(in_ch.now_ms, in_ch.distance_cm));

			pending = expected_results.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the distance presence detector. A directed sequence walks the
// timing rules, time wrap, register extremes and the empty baseline cases;
// then randomly configured phases send well-formed time series with random
// distances while both channels stall in bursts. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
	import dpat_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_TAIL   = 100;
	localparam int DRAIN_CYCLES = 30;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  quiet;
	int                    errors;
	int                    pending;

	dpat_in_if  in_ch ();
	dpat_out_if out_ch ();

	distance_presence_adaptive_threshold u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dpat_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The run must never get this far.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("distance_presence_adaptive_threshold verification failed");
		$finish;
	end

	// Result side: ready alternates between runs high and stall bursts.
	initial begin : receiver
		int   run;
		logic take;
		out_ch.ready = 1'b0;
		run = 0;
		take = 1'b0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				take = ($urandom_range(0, 3) != 0);
				run = take ? $urandom_range(1, 12) : $urandom_range(1, 6);
			end
			run--;
			out_ch.ready <= take || quiet;
		end
	end

	// One sample transfer; valid stays high when the next call follows.
	task automatic transfer_sample(logic [TIME_W-1:0] t, logic [DIST_W-1:0] d);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.now_ms <= t;
		in_ch.distance_cm <= d;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	task automatic sender_gap(int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
	endtask

	// Holds the sender until every predicted result has been taken.
	task automatic settle();
		sender_gap(1);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(logic [TIME_W-1:0] t, logic [DIST_W-1:0] d);
		if (!quiet) begin
			if ($urandom_range(0, 59) == 0)
				settle();
			else if ($urandom_range(0, 3) == 0)
				sender_gap($urandom_range(1, 6));
		end
		transfer_sample(t, d);
	endtask

	// Bits above a register's width are don't-care and get random values.
	function automatic logic [CFG_DATA_W-1:0] with_spare_bits(logic [CFG_DATA_W-1:0] v, int w);
		return v | (CFG_DATA_W'($urandom) << w);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned hi, int unsigned typical);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'(hi);
			default: return CFG_DATA_W'($urandom_range(0, typical));
		endcase
	endfunction

	initial begin : stimulus
		logic [TIME_W-1:0]     clock_ms;
		logic [DIST_W-1:0]     dist_cm;
		logic [CFG_DATA_W-1:0] en_v, sense_v, sens_v, delay_v, def_v, period_v;
		int                    phase;
		int                    sent;
		int                    n_items;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.now_ms = '0;
		in_ch.distance_cm = '0;
		quiet = 1'b0;
		dist_cm = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: sense interval, no change, presence set and timed out,
		// a baseline sample, and the time counter wrapping.
		send_sample(32'd0, 9'd0);
		send_sample(32'd100, 9'd50);
		send_sample(32'd150, 9'd50);
		send_sample(32'd200, 9'd51);
		send_sample(32'd300, 9'd511);
		send_sample(32'd400, 9'd511);
		send_sample(32'd6000, 9'd0);
		send_sample(32'd60000, 9'd80);
		send_sample(32'hFFFF_FFF0, 9'd30);
		send_sample(32'h0000_0050, 9'd200);
		send_sample(32'h0000_0060, 9'd200);

		// Every item sampled and entering the ring; empty entries count as zero.
		settle();
		write_reg(REG_SENSE_INTERVAL, '0);
		write_reg(REG_BASELINE_PERIOD, '0);
		write_reg(REG_DEFAULT_THR, '0);
		write_reg(REG_CHANGE_SENS, '0);
		repeat (6) send_sample(32'h0000_0061, 9'd0);

		// Largest default threshold and a sensitivity no change can exceed.
		settle();
		write_reg(REG_DEFAULT_THR, 20'd511);
		write_reg(REG_CHANGE_SENS, 20'd511);
		write_reg(REG_CLEAR_DELAY, '0);
		send_sample(32'h0000_0062, 9'd0);
		send_sample(32'h0000_0063, 9'd511);

		// Largest intervals.
		settle();
		write_reg(REG_CHANGE_SENS, '0);
		write_reg(REG_CLEAR_DELAY, 20'hF_FFFF);
		write_reg(REG_SENSE_INTERVAL, 20'h0_FFFF);
		write_reg(REG_BASELINE_PERIOD, 20'hF_FFFF);
		send_sample(32'h0001_0062, 9'd300);
		send_sample(32'h0001_0063, 9'd10);

		// Sensor off, and writes past the register list.
		settle();
		write_reg(REG_ENABLE, 20'hF_FFFE);
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		send_sample(32'h0020_0000, 9'd5);
		send_sample(32'h0040_0000, 9'd0);
		settle();
		write_reg(REG_ENABLE, 20'h0_0001);

		// Random phases: a fresh setting each, then a running time series.
		clock_ms = $urandom;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
			if (phase == 0) begin
				en_v = 20'd1;
				sense_v = 20'h0_FFFF;
				sens_v = 20'd511;
				delay_v = 20'hF_FFFF;
				def_v = 20'd511;
				period_v = 20'hF_FFFF;
			end else if (phase == 1) begin
				en_v = 20'd1;
				sense_v = '0;
				sens_v = '0;
				delay_v = '0;
				def_v = '0;
				period_v = 20'd1;
			end else begin
				en_v = ($urandom_range(0, 7) != 0) ? 20'd1 : 20'd0;
				sense_v = pick_setting(16'hFFFF, 150);
				sens_v = pick_setting(511, 30);
				delay_v = pick_setting(20'hF_FFFF, 3000);
				def_v = pick_setting(511, 511);
				period_v = pick_setting(20'hF_FFFF, 2000);
			end
			write_reg(REG_ENABLE, with_spare_bits(en_v, 1));
			write_reg(REG_SENSE_INTERVAL, with_spare_bits(sense_v, SENSE_W));
			write_reg(REG_CHANGE_SENS, with_spare_bits(sens_v, SENS_W));
			write_reg(REG_CLEAR_DELAY, delay_v);
			write_reg(REG_DEFAULT_THR, with_spare_bits(def_v, DIST_W));
			write_reg(REG_BASELINE_PERIOD, period_v);

			n_items = en_v[0] ? 40 : 8;
			for (int i = 0; i < n_items; i++) begin
				// Mostly steps around the sense interval, now and then a long
				// stretch or a jump anywhere in the time range.
				case ($urandom_range(0, 19))
					0: clock_ms = $urandom;
					1: clock_ms += $urandom_range(0, 20'hF_FFFF);
					default: clock_ms += $urandom_range(0, 2 * int'(sense_v) + 40);
				endcase
				case ($urandom_range(0, 7))
					0: dist_cm = '0;
					1, 2: dist_cm = dist_cm ^ DIST_W'($urandom_range(0, 7));
					3: dist_cm = DIST_W'($urandom_range(0, int'(def_v)));
					default: dist_cm = DIST_W'($urandom);
				endcase
				send_sample(clock_ms, dist_cm);
				if (en_v[0])
					sent++;
			end
			phase++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("distance_presence_adaptive_threshold verification clean");
		else
			$display("distance_presence_adaptive_threshold verification failed");
		$finish;
	end

endmodule
